FILE: sv/acia_pkg.sv
// Shared types, codes and constants for the serial ACIA register block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package acia_pkg;

    // Access kinds carried by an input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_TICK  = 2'd3
    } acia_cmd_t;

    // Register map, 6551 order
    typedef enum logic [1:0] {
        REG_DATA    = 2'd0,
        REG_STATUS  = 2'd1,
        REG_COMMAND = 2'd2,
        REG_CONTROL = 2'd3
    } acia_sel_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NMI_SELECT  = 1'b1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PERIOD_RESET    = 16'd21111;
    localparam logic [7:0]  TDRE_CLEAR_MASK = 8'hef;
    localparam logic [7:0]  CMD_KEEP_MASK   = 8'he0;
    localparam logic [7:0]  TDRE_BIT        = 8'h10;
    localparam logic [7:0]  IRQ_BIT         = 8'h80;
    localparam logic [7:0]  RDRF_BIT        = 8'h08;
    localparam logic [7:0]  OVR_BIT         = 8'h04;
    localparam logic [7:0]  STATUS_RESET    = TDRE_BIT;

    localparam logic [1:0]  TX_PEND_NONE = 2'd0;
    localparam logic [1:0]  TX_PEND_ONE  = 2'd1;
    localparam logic [1:0]  TX_PEND_FULL = 2'd2;

    // One input word
    typedef struct packed {
        acia_cmd_t  cmd;
        acia_sel_t  reg_sel;
        logic [7:0] wdata;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } acia_item_t;

    // One result word
    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
        logic       irq_active;
        logic       irq_is_nmi;
    } acia_result_t;

endpackage

`default_nettype wire

FILE: sv/acia_serial_port_registers.sv
// Simplified serial ACIA register block with 6551 register order.
// Each s_ word is a register write, a read, a side-effect-free peek or one
// clock tick; each gives exactly one m_ word with the read byte, any byte
// sent to the line, whether an offered receive byte was taken, and the
// interrupt level and kind.
// A word in the input register is applied to the registers when it moves
// into the result register, and its result is shown on m_ from then on.
// Throughput: one word per cycle while m_ready stays high; the input
// register and the result register are the only stages, with one pass of
// byte logic between them.
// When m_ready is low a full result register holds its word, and the
// input register takes a word only while it is empty; s_ready then drops
// until m_ready returns. Reset empties both stages and returns all
// registers to their reset values: status shows transmit empty, link
// closed, alarm disarmed, tick period 21111 and maskable interrupt kind.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
// once; index 0 is the tick period, index 1 the interrupt kind.
// Depends on acia_pkg, acia_in_stage, acia_core and acia_out_stage.
`default_nettype none

module acia_serial_port_registers (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [acia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [acia_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_cmd,
    input  wire logic [1:0]                      s_reg_sel,
    input  wire logic [7:0]                      s_wdata,
    input  wire logic                            s_rx_valid,
    input  wire logic [7:0]                      s_rx_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_rdata,
    output logic                                 m_tx_valid,
    output logic [7:0]                           m_tx_byte,
    output logic                                 m_rx_taken,
    output logic                                 m_irq_active,
    output logic                                 m_irq_is_nmi
);

    acia_pkg::acia_item_t   s_item;
    acia_pkg::acia_item_t   item;
    acia_pkg::acia_result_t result;
    acia_pkg::acia_result_t m_result;
    logic                   item_valid;
    logic                   advance;

    // Pack the input word
    always_comb begin
        s_item.cmd      = acia_pkg::acia_cmd_t'(s_cmd);
        s_item.reg_sel  = acia_pkg::acia_sel_t'(s_reg_sel);
        s_item.wdata    = s_wdata;
        s_item.rx_valid = s_rx_valid;
        s_item.rx_byte  = s_rx_byte;
    end

    acia_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    acia_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    acia_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    // Unpack the result word
    assign m_rdata      = m_result.rdata;
    assign m_tx_valid   = m_result.tx_valid;
    assign m_tx_byte    = m_result.tx_byte;
    assign m_rx_taken   = m_result.rx_taken;
    assign m_irq_active = m_result.irq_active;
    assign m_irq_is_nmi = m_result.irq_is_nmi;

endmodule

`default_nettype wire

FILE: sv/acia_in_stage.sv
// Input register of the ACIA block: captures one word from the s_ channel.
// Depends on acia_pkg for the item type.
`default_nettype none

module acia_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire acia_pkg::acia_item_t s_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output acia_pkg::acia_item_t   item
);

    logic                 valid_reg;
    acia_pkg::acia_item_t item_reg;

    // Accept when empty or when the held word moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Capture the payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/acia_core.sv
// Register file and service logic of the ACIA: applies one word per cycle while the result register takes it.
// Depends on acia_pkg for codes, masks and the item/result types.
`default_nettype none

module acia_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [acia_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [acia_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 advance,
    input  wire acia_pkg::acia_item_t                 item,
    output acia_pkg::acia_result_t                    result
);

    logic [15:0] tick_period_reg;
    logic        nmi_select_reg;

    logic [7:0]  command_reg,  command_next;
    logic [7:0]  control_reg,  control_next;
    logic [7:0]  status_reg,   status_next;
    logic [7:0]  rx_byte_reg,  rx_byte_next;
    logic [7:0]  tx_byte_reg,  tx_byte_next;
    logic [1:0]  tx_pend_reg,  tx_pend_next;
    logic        link_reg,     link_next;
    logic        irq_reg,      irq_next;
    logic        armed_reg,    armed_next;
    logic [15:0] alarm_reg,    alarm_next;

    logic [7:0]  view;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= acia_pkg::PERIOD_RESET;
            nmi_select_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                acia_pkg::CFG_TICK_PERIOD: tick_period_reg <= cfg_wdata[15:0];
                acia_pkg::CFG_NMI_SELECT:  nmi_select_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Register view for reads and peeks
    always_comb begin
        case (item.reg_sel)
            acia_pkg::REG_DATA:    view = rx_byte_reg;
            acia_pkg::REG_STATUS:  view = status_reg | (irq_reg ? acia_pkg::IRQ_BIT : 8'h00);
            acia_pkg::REG_COMMAND: view = command_reg;
            default:               view = control_reg;
        endcase
    end

    // Next state and result for the word at the input register
    always_comb begin
        command_next = command_reg;
        control_next = control_reg;
        status_next  = status_reg;
        rx_byte_next = rx_byte_reg;
        tx_byte_next = tx_byte_reg;
        tx_pend_next = tx_pend_reg;
        link_next    = link_reg;
        irq_next     = irq_reg;
        armed_next   = armed_reg;
        alarm_next   = alarm_reg;
        result       = '0;

        case (item.cmd)
            acia_pkg::CMD_WRITE: begin
                case (item.reg_sel)
                    acia_pkg::REG_DATA: begin
                        tx_byte_next = item.wdata;
                        if (command_reg[0]) begin
                            if (tx_pend_reg == acia_pkg::TX_PEND_NONE) begin
                                armed_next   = 1'b1;
                                alarm_next   = 16'd1;
                                tx_pend_next = acia_pkg::TX_PEND_FULL;
                            end else if (tx_pend_reg == acia_pkg::TX_PEND_ONE) begin
                                tx_pend_next = acia_pkg::TX_PEND_FULL;
                            end
                            status_next = status_reg & acia_pkg::TDRE_CLEAR_MASK;
                        end
                    end
                    acia_pkg::REG_STATUS: begin
                        // Programmed reset
                        link_next    = 1'b0;
                        status_next  = status_reg & ~acia_pkg::OVR_BIT;
                        command_next = command_reg & acia_pkg::CMD_KEEP_MASK;
                        tx_pend_next = acia_pkg::TX_PEND_NONE;
                        irq_next     = 1'b0;
                        armed_next   = 1'b0;
                    end
                    acia_pkg::REG_COMMAND: begin
                        command_next = item.wdata;
                        if (item.wdata[0] && !link_reg) begin
                            link_next  = 1'b1;
                            armed_next = 1'b1;
                            alarm_next = tick_period_reg;
                        end else if (link_reg && !item.wdata[0]) begin
                            link_next  = 1'b0;
                            armed_next = 1'b0;
                        end
                    end
                    default: begin
                        control_next = item.wdata;
                    end
                endcase
            end
            acia_pkg::CMD_READ: begin
                result.rdata = view;
                if (item.reg_sel == acia_pkg::REG_DATA) begin
                    status_next = status_reg & ~acia_pkg::RDRF_BIT;
                end else if (item.reg_sel == acia_pkg::REG_STATUS) begin
                    irq_next = 1'b0;
                end
            end
            acia_pkg::CMD_PEEK: begin
                result.rdata = view;
            end
            default: begin
                // Clock tick: when armed, count down and service the line when the alarm expires
                if (armed_reg) begin
                    if (alarm_reg > 16'd1) begin
                        alarm_next = alarm_reg - 16'd1;
                    end else begin
                        if (tx_pend_reg == acia_pkg::TX_PEND_FULL && link_reg) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = tx_byte_reg;
                        end
                        if (tx_pend_reg != acia_pkg::TX_PEND_NONE) begin
                            tx_pend_next = tx_pend_reg - 2'd1;
                        end
                        if (link_reg && !status_reg[3] && item.rx_valid) begin
                            rx_byte_next    = item.rx_byte;
                            status_next     = status_reg | acia_pkg::TDRE_BIT
                                              | acia_pkg::RDRF_BIT;
                            result.rx_taken = 1'b1;
                        end else begin
                            status_next = status_reg | acia_pkg::TDRE_BIT;
                        end
                        irq_next   = 1'b1;
                        alarm_next = tick_period_reg;
                    end
                end
            end
        endcase

        result.irq_active = irq_next;
        result.irq_is_nmi = nmi_select_reg;
    end

    // Commit state when the word moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg <= 8'h00;
            control_reg <= 8'h00;
            status_reg  <= acia_pkg::STATUS_RESET;
            rx_byte_reg <= 8'h00;
            tx_byte_reg <= 8'h00;
            tx_pend_reg <= acia_pkg::TX_PEND_NONE;
            link_reg    <= 1'b0;
            irq_reg     <= 1'b0;
            armed_reg   <= 1'b0;
            alarm_reg   <= 16'd0;
        end else if (advance) begin
            command_reg <= command_next;
            control_reg <= control_next;
            status_reg  <= status_next;
            rx_byte_reg <= rx_byte_next;
            tx_byte_reg <= tx_byte_next;
            tx_pend_reg <= tx_pend_next;
            link_reg    <= link_next;
            irq_reg     <= irq_next;
            armed_reg   <= armed_next;
            alarm_reg   <= alarm_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/acia_out_stage.sv
// Result register of the ACIA block: holds one word for the m_ channel.
// Depends on acia_pkg for the result type.
`default_nettype none

module acia_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   item_valid,
    input  wire acia_pkg::acia_result_t result,
    output logic                        advance,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output acia_pkg::acia_result_t      m_result
);

    logic                   valid_reg;
    acia_pkg::acia_result_t result_reg;

    // Move a word in when the register is free or is being drained
    assign advance  = item_valid && (!valid_reg || m_ready);
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the result
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire
